>>> rtl/core/one_wire_bus_master_macros.svh
// Assertion macros used by the checker file of the 1-Wire bus master
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define OWBM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define OWBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/owbm_pkg.sv
// Shared types, codes, bus timing constants and command decode of the 1-Wire bus master
package owbm_pkg;

	// operation codes
	localparam logic [2:0] OP_NONE    = 3'd0;
	localparam logic [2:0] OP_RESET   = 3'd1;
	localparam logic [2:0] OP_WRITE   = 3'd2;
	localparam logic [2:0] OP_READ    = 3'd3;
	localparam logic [2:0] OP_CONVERT = 3'd4;
	localparam logic [2:0] OP_TEMP    = 3'd5;

	// slot kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_RESET = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	// slot timing in microseconds
	localparam logic [9:0] RESET_LOW_US      = 10'd480;
	localparam logic [9:0] RESET_SAMPLE_US   = 10'd560;
	localparam logic [9:0] RESET_END_US      = 10'd960;
	localparam logic [9:0] WRITE_ONE_LOW_US  = 10'd6;
	localparam logic [9:0] WRITE_ZERO_LOW_US = 10'd60;
	localparam logic [9:0] WRITE_END_US      = 10'd70;
	localparam logic [9:0] READ_LOW_US       = 10'd2;
	localparam logic [9:0] READ_SAMPLE_US    = 10'd15;
	localparam logic [9:0] READ_END_US       = 10'd60;

	// ROM and function commands
	localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_PAD = 8'hBE;

	localparam logic [7:0] CPU_RESET = 8'd96;

	// input item as it travels through the queue, with its class
	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] send_byte;
		logic       line_level;
		logic       is_cmd;
	} item_t;

	// what the next step of a sequence starts
	typedef struct packed {
		logic       ok;
		logic [1:0] kind;
		logic       load;
		logic [7:0] value;
	} launch_t;

	function automatic launch_t launch_f(input logic [2:0] cmd, input logic [2:0] step,
		input logic [7:0] first_byte);
		launch_t l;
		l = '{ok: 1'b0, kind: KIND_NONE, load: 1'b0, value: 8'h00};
		if (step == 3'd0) begin
			case (cmd)
				OP_RESET, OP_CONVERT, OP_TEMP: begin
					l.ok = 1'b1;
					l.kind = KIND_RESET;
				end
				OP_WRITE: begin
					l = '{ok: 1'b1, kind: KIND_WRITE, load: 1'b1, value: first_byte};
				end
				OP_READ: begin
					l = '{ok: 1'b1, kind: KIND_READ, load: 1'b1, value: 8'h00};
				end
				default: l.ok = 1'b0;
			endcase
		end else if (cmd == OP_CONVERT || cmd == OP_TEMP) begin
			if (step == 3'd1) begin
				l = '{ok: 1'b1, kind: KIND_WRITE, load: 1'b1, value: CMD_SKIP_ROM};
			end else if (step == 3'd2) begin
				l = '{ok: 1'b1, kind: KIND_WRITE, load: 1'b1,
					value: (cmd == OP_CONVERT) ? CMD_CONVERT : CMD_READ_PAD};
			end else if (cmd == OP_TEMP && (step == 3'd3 || step == 3'd4)) begin
				l = '{ok: 1'b1, kind: KIND_READ, load: 1'b1, value: 8'h00};
			end
		end
		return l;
	endfunction

endpackage

>>> rtl/core/owbm_channels.sv
// Handshake channel interfaces: input items, results and the divider register write
interface owbm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] send_byte;
	logic       line_level;
	modport source (output valid, output operation, output send_byte, output line_level,
		input ready);
	modport sink (input valid, input operation, input send_byte, input line_level,
		output ready);
endinterface

interface owbm_out_if;
	logic              valid;
	logic              ready;
	logic              pull_low;
	logic              busy_res;
	logic              finished;
	logic              status;
	logic [7:0]        received_byte;
	logic signed [15:0] temperature;
	modport source (output valid, output pull_low, output busy_res, output finished,
		output status, output received_byte, output temperature, input ready);
	modport sink (input valid, input pull_low, input busy_res, input finished,
		input status, input received_byte, input temperature, output ready);
endinterface

interface owbm_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/owbm_front.sv
// Front end: accepts input transactions, tags real commands, two-entry queue to the engine
module owbm_front
	import owbm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	owbm_in_if.sink    in_ch,
	input  logic       pop,
	output logic       head_valid,
	output item_t      head
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	item_t      tagged_item;

	assign in_ch.ready = (count_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign head_valid  = (count_q != 2'd0);
	assign head        = slot_q[rd_ptr_q];

	// classify: only operations 1 to 5 start a sequence
	always_comb begin
		tagged_item.operation  = in_ch.operation;
		tagged_item.send_byte  = in_ch.send_byte;
		tagged_item.line_level = in_ch.line_level;
		tagged_item.is_cmd     = (in_ch.operation >= OP_RESET) && (in_ch.operation <= OP_TEMP);
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= tagged_item;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> rtl/core/owbm_engine.sv
// Back end: bit-timing engine, one queued transaction per cycle while the result is taken, result register
module owbm_engine
	import owbm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] cpu,
	input  logic       head_valid,
	input  item_t      head,
	output logic       pop,
	owbm_out_if.source out_ch
);

	// sequence state
	logic [2:0] cmd_q, cmd_n;
	logic [1:0] kind_q, kind_n;
	logic [7:0] pre_q, pre_n;
	logic [9:0] slot_q, slot_n;
	logic [2:0] bit_q, bit_n;
	logic [2:0] seq_q, seq_n;
	logic [7:0] shift_q, shift_n;
	logic [15:0] temp_q, temp_n;
	logic        pres_q, pres_n;

	// result register
	logic        out_valid_q;
	logic        pull_q, busy_q, fin_q, status_q;
	logic [7:0]  rx_q;
	logic [15:0] tout_q;

	logic        fire;
	logic        pull_n, fin_n, status_n;
	logic [7:0]  rx_n;
	logic [15:0] tout_n;
	logic [7:0]  limit;
	logic        tick, end_now, do_adv, do_finish, finish_ok;
	launch_t     l_first, l_next;

	assign fire = head_valid && (!out_valid_q || out_ch.ready);
	assign pop  = fire;

	assign limit   = (cpu == 8'd0) ? 8'd1 : cpu;
	assign l_first = launch_f(head.operation, 3'd0, head.send_byte);
	assign l_next  = launch_f(cmd_q, seq_q + 3'd1, 8'h00);

	// next state for one transaction
	always_comb begin
		cmd_n = cmd_q; kind_n = kind_q; pre_n = pre_q; slot_n = slot_q; bit_n = bit_q;
		seq_n = seq_q; shift_n = shift_q; temp_n = temp_q; pres_n = pres_q;
		fin_n = 1'b0; status_n = 1'b0; rx_n = 8'h00; tout_n = 16'h0000;
		tick = 1'b0; end_now = 1'b0; do_adv = 1'b0; do_finish = 1'b0; finish_ok = 1'b0;
		pull_n = 1'b0;

		if (cmd_q == OP_NONE && kind_q == KIND_NONE) begin
			// idle: start a command
			if (head.is_cmd) begin
				cmd_n  = head.operation;
				seq_n  = 3'd0;
				pres_n = 1'b0;
				kind_n = l_first.kind;
				slot_n = 10'd0;
				pre_n  = 8'd0;
				if (l_first.load) begin
					bit_n   = 3'd0;
					shift_n = l_first.value;
				end
			end
		end else begin
			// prescaler
			if ({1'b0, pre_q} + 9'd1 >= {1'b0, limit}) begin
				pre_n = 8'd0;
				tick  = 1'b1;
			end else begin
				pre_n = pre_q + 8'd1;
			end
			if (tick) begin
				slot_n = slot_q + 10'd1;
				case (kind_q)
					KIND_RESET: begin
						if (slot_n == RESET_SAMPLE_US) pres_n = ~head.line_level;
						end_now = (slot_n == RESET_END_US);
					end
					KIND_WRITE: end_now = (slot_n == WRITE_END_US);
					KIND_READ: begin
						if (slot_n == READ_SAMPLE_US) shift_n = {head.line_level, shift_q[7:1]};
						end_now = (slot_n == READ_END_US);
					end
					default: begin
						cmd_n  = OP_NONE;
						kind_n = KIND_NONE;
						seq_n  = 3'd0;
					end
				endcase
			end
			// end of slot
			if (end_now) begin
				if (kind_q == KIND_RESET) begin
					if (!pres_n) begin
						do_finish = 1'b1;
					end else begin
						do_adv = 1'b1;
					end
				end else begin
					if (kind_q == KIND_WRITE) shift_n = {1'b0, shift_n[7:1]};
					if (bit_q != 3'd7) begin
						bit_n  = bit_q + 3'd1;
						slot_n = 10'd0;
						pre_n  = 8'd0;
					end else begin
						if (cmd_q == OP_TEMP && seq_q == 3'd3) temp_n[7:0] = shift_n;
						else if (cmd_q == OP_TEMP && seq_q == 3'd4) temp_n[15:8] = shift_n;
						do_adv = 1'b1;
					end
				end
			end
			// next step of the sequence
			if (do_adv) begin
				seq_n = seq_q + 3'd1;
				if (l_next.ok) begin
					kind_n = l_next.kind;
					slot_n = 10'd0;
					pre_n  = 8'd0;
					if (l_next.load) begin
						bit_n   = 3'd0;
						shift_n = l_next.value;
					end
				end else begin
					do_finish = 1'b1;
					finish_ok = 1'b1;
				end
			end
			// sequence complete
			if (do_finish) begin
				fin_n    = 1'b1;
				status_n = ~finish_ok;
				if (finish_ok && (cmd_q == OP_READ || cmd_q == OP_TEMP)) rx_n = shift_n;
				if (finish_ok && cmd_q == OP_TEMP) tout_n = temp_n;
				cmd_n  = OP_NONE;
				kind_n = KIND_NONE;
				seq_n  = 3'd0;
				slot_n = 10'd0;
				pre_n  = 8'd0;
				bit_n  = 3'd0;
			end
		end

		// line drive from the updated state
		case (kind_n)
			KIND_RESET: pull_n = (slot_n < RESET_LOW_US);
			KIND_WRITE: pull_n = (slot_n < (shift_n[0] ? WRITE_ONE_LOW_US : WRITE_ZERO_LOW_US));
			KIND_READ:  pull_n = (slot_n < READ_LOW_US);
			default:    pull_n = 1'b0;
		endcase
		if (cmd_n == OP_NONE && kind_n == KIND_NONE) pull_n = 1'b0;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= OP_NONE;
			kind_q  <= KIND_NONE;
			pre_q   <= 8'd0;
			slot_q  <= 10'd0;
			bit_q   <= 3'd0;
			seq_q   <= 3'd0;
			shift_q <= 8'd0;
			temp_q  <= 16'd0;
			pres_q  <= 1'b0;
		end else if (fire) begin
			cmd_q   <= cmd_n;
			kind_q  <= kind_n;
			pre_q   <= pre_n;
			slot_q  <= slot_n;
			bit_q   <= bit_n;
			seq_q   <= seq_n;
			shift_q <= shift_n;
			temp_q  <= temp_n;
			pres_q  <= pres_n;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			pull_q   <= pull_n;
			busy_q   <= (cmd_n != OP_NONE) || (kind_n != KIND_NONE);
			fin_q    <= fin_n;
			status_q <= status_n;
			rx_q     <= rx_n;
			tout_q   <= tout_n;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.pull_low      = pull_q;
	assign out_ch.busy_res      = busy_q;
	assign out_ch.finished      = fin_q;
	assign out_ch.status        = status_q;
	assign out_ch.received_byte = rx_q;
	assign out_ch.temperature   = signed'(tout_q);

endmodule

>>> rtl/core/one_wire_bus_master.sv
// 1-Wire bus master top level: divider register, front queue and timing engine
//
// Usage: each input transaction is one clock cycle of bus time. It carries an
// operation (0 none, 1 bus reset, 2 write byte, 3 read byte, 4 convert,
// 5 read temperature), the byte to send and the sampled line level. Every
// input transaction yields exactly one result transaction: line drive,
// busy flag, finish pulse, presence status, received byte and temperature.
// A command is taken only while no sequence runs; otherwise it is ignored.
// The cfg channel writes cycles_per_microsecond (reset 96); write it only
// while idle. cfg is always ready.
// An accepted input waits in the front queue until the engine takes it, and
// the engine then writes its result into the result register.
// Throughput: one transaction per cycle while results are taken, as the engine
// updates the slot timer, prescaler and shift register for each transaction.
// A two-entry queue parts input from engine and a result register holds the
// output, so a stalled receiver back-pressures the input once the queue fills.
// Reset (arst_n low) returns the engine to idle and empties queue and result.
module one_wire_bus_master
	import owbm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	owbm_in_if.sink    in_ch,
	owbm_out_if.source out_ch,
	owbm_cfg_if.sink   cfg
);

	logic [7:0] cpu_q;
	logic       pop;
	logic       head_valid;
	item_t      head;

	// divider register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_q <= CPU_RESET;
		end else if (cfg.valid) begin
			cpu_q <= cfg.data;
		end
	end

	owbm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	owbm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cpu        (cpu_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

>>> rtl/core/owbm_checker.sv
// Port-level checker for the 1-Wire bus master and its bind
`include "one_wire_bus_master_macros.svh"

module owbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        busy_res,
	input logic        finished,
	input logic        status,
	input logic        pull_low,
	input logic [7:0]  received_byte,
	input logic [15:0] temperature
);

	logic [27:0] res_bits;
	logic        stalled;
	logic        has_data;

	assign res_bits = {busy_res, finished, status, pull_low, received_byte, temperature};
	assign stalled  = out_valid && !out_ready;
	assign has_data = (received_byte != 8'h00) || (temperature != 16'h0000);

	// a stalled result holds
	`OWBM_ASSERT_NEXT(a_hold, stalled, out_valid && $stable(res_bits), "stalled result changed")

	// a finishing result shows the block idle and the line released
	`OWBM_ASSERT(a_fin_idle, !(out_valid && finished) || (!busy_res && !pull_low), "busy at finish")

	// status, byte and temperature appear only when a sequence ends
	`OWBM_ASSERT(a_status_fin, !(out_valid && status) || finished, "status without finish")

	`OWBM_ASSERT(a_data_fin, !(out_valid && has_data) || (finished && !status), "data outside finish")

	// the line is only driven inside a sequence
	`OWBM_ASSERT(a_pull_busy, !(out_valid && pull_low) || busy_res, "line driven while idle")

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.busy_res      (out_ch.busy_res),
	.finished      (out_ch.finished),
	.status        (out_ch.status),
	.pull_low      (out_ch.pull_low),
	.received_byte (out_ch.received_byte),
	.temperature   (out_ch.temperature)
);
